### design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding-window maximum core.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CFG_W = 7;

    typedef struct packed {
        logic step;
        logic shift;
        logic clear;
    } t_swm_ctl;

endpackage

### design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One candidate slot of the queue: holds value, age and valid, compares
// against the incoming sample and takes data from its right neighbor.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_W       = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_swm_ctl             i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_left_keep,
    input  logic                          i_right_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_right_value,
    input  logic [AGE_W-1:0]              i_right_age,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic [AGE_W-1:0]              o_age,
    output logic                          o_keep
);
    import swm_pkg::*;

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic [AGE_W-1:0]              r_age;
    logic                          n_valid;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic [AGE_W-1:0]              n_age;

    logic                          src_valid;
    logic signed [SAMPLE_BITS-1:0] src_value;
    logic [AGE_W-1:0]              src_age;
    logic [AGE_W:0]                age_inc;
    logic                          keep;

    always_comb begin
        src_valid = i_ctl.shift ? i_right_valid : r_valid;
        src_value = i_ctl.shift ? i_right_value : r_value;
        src_age   = i_ctl.shift ? i_right_age   : r_age;
        if (i_ctl.clear) begin
            src_valid = 1'b0;
        end
        age_inc = {1'b0, src_age} + (AGE_W+1)'(1);
        keep    = src_valid && !(i_sample > src_value);
    end

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.step) begin
            n_valid = keep | i_left_keep;
            n_value = keep ? src_value : i_sample;
            n_age   = keep ? age_inc[AGE_W-1:0] : '0;
        end else if (i_ctl.shift) begin
            n_valid = src_valid;
            n_value = src_value;
            n_age   = src_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_keep  = keep;

endmodule

### design/sliding_window_maximum_core.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Running maximum over the last window_len signed samples (0 acts as 1, capped at
// MAX_WINDOW), kept as a non-increasing candidate queue spread over a row of cells.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s stream  in   i_s_tvalid/o_s_tready tdata: sample; tuser: start_new
// m stream  out  o_m_tvalid/i_m_tready tdata: window_max
// cfg       in   i_cfg_wen             window_len
//
// One sample per cycle when not stalled; each result appears the cycle after its sample.
// All cells compare and shift in the same cycle, so, when not stalled, the rate is
// one sample a clock regardless of window length.
// Reset is synchronous; the queue comes out empty, window_len is 1.
// A window_len write drains stale front candidates, one per cycle once the output
// is empty, before the next sample is taken. A stalled output holds the input.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    i_s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                i_s_tuser,  // [0] start_new
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    o_m_tdata,  // [SAMPLE_BITS-1:0] window_max
    input  logic                                i_cfg_wen,
    input  logic [swm_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import swm_pkg::*;

    localparam int AGE_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (AGE_W + 1 > CFG_W) ? AGE_W + 1 : CFG_W;

    logic [CFG_W-1:0] r_win_len;
    logic             r_clean;
    logic             n_clean;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;

    logic                          c_valid [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] c_value [MAX_WINDOW];
    logic [AGE_W-1:0]              c_age   [MAX_WINDOW];
    logic                          c_keep  [MAX_WINDOW];

    t_swm_ctl                      ctl;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CMP_W-1:0]              w_eff;
    logic [CMP_W-1:0]              front_age;
    logic                          hit;
    logic                          step;
    logic                          clean_go;
    logic [CNT_W-1:0]              fill_base;

    assign sample     = i_s_tdata[SAMPLE_BITS-1:0];
    assign o_s_tready = !r_clean && (!r_out_valid || i_m_tready);
    assign step       = i_s_tvalid && o_s_tready;
    assign clean_go   = r_clean && !r_out_valid;

    always_comb begin
        if (r_win_len == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_win_len) > CMP_W'(MAX_WINDOW)) begin
            w_eff = CMP_W'(MAX_WINDOW);
        end else begin
            w_eff = CMP_W'(r_win_len);
        end
        front_age = CMP_W'(c_age[0]) + CMP_W'(1);
        hit       = c_valid[0] && (front_age >= w_eff);

        ctl.step  = step;
        ctl.clear = step && i_s_tuser;
        ctl.shift = (step && !i_s_tuser && hit) || (clean_go && hit);
    end

    always_comb begin
        fill_base = (step && i_s_tuser) ? '0 : r_fill;
        n_fill    = r_fill;
        if (step) begin
            n_fill = (fill_base == CNT_W'(MAX_WINDOW)) ? fill_base : fill_base + CNT_W'(1);
        end

        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = CMP_W'(n_fill) >= w_eff;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        n_clean = r_clean;
        if (i_cfg_wen) begin
            n_clean = 1'b1;
        end else if (clean_go && !hit) begin
            n_clean = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= CFG_W'(1);
            r_clean     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_win_len <= i_cfg_wdata;
            end
            r_clean     <= n_clean;
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic                          left_keep;
        logic                          right_valid;
        logic signed [SAMPLE_BITS-1:0] right_value;
        logic [AGE_W-1:0]              right_age;

        if (i == 0) begin : g_head
            assign left_keep = 1'b1;
        end else begin : g_body
            assign left_keep = c_keep[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_value = '0;
            assign right_age   = '0;
        end else begin : g_link
            assign right_valid = c_valid[i+1];
            assign right_value = c_value[i+1];
            assign right_age   = c_age[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_sample      (sample),
            .i_left_keep   (left_keep),
            .i_right_valid (right_valid),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .o_valid       (c_valid[i]),
            .o_value       (c_value[i]),
            .o_age         (c_age[i]),
            .o_keep        (c_keep[i])
        );
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata                    = '0;
        o_m_tdata[SAMPLE_BITS-1:0]   = c_value[0];
    end

endmodule

### verif/sliding_window_maximum_core_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_core_tb
// Self-checking bench for the sliding-window maximum core. A scoreboard keeps
// its own candidate queue per accepted sample and predicts each window
// maximum; directed corner samples come first, then random phases under
// varying window lengths, random stalls on both streams and one long
// back-pressure hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_maximum_core_tb;

    localparam int MAX_WIN   = 64;
    localparam int SMP_W     = 32;
    localparam int RAND_ITEMS = 1850;
    localparam int STALL_LIMIT = 4000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [SMP_W-1:0]          i_s_tdata;   // [31:0] sample
    logic                      i_s_tuser;   // [0] start_new
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [SMP_W-1:0]          o_m_tdata;   // [31:0] window_max
    logic                      i_cfg_wen;
    logic [swm_pkg::CFG_W-1:0] i_cfg_wdata;

    class swm_scoreboard;
        logic signed [SMP_W-1:0] exp_q[$];
        logic signed [SMP_W-1:0] cand_val[MAX_WIN];
        logic [5:0]              cand_pos[MAX_WIN];
        int unsigned             depth;
        logic [5:0]              pos;
        int unsigned             fill;
        logic [swm_pkg::CFG_W-1:0] win;
        int unsigned             n_in, n_out, n_err, n_restart;

        function new();
            win = 7'd1;
            depth = 0;
            pos = '0;
            fill = 0;
            n_in = 0;
            n_out = 0;
            n_err = 0;
            n_restart = 0;
        endfunction

        function void set_window(logic [swm_pkg::CFG_W-1:0] v);
            win = v;
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] s, logic restart);
            int unsigned w;
            int unsigned age;
            logic [5:0]  d;
            bit          stale;
            w = (win == 0) ? 1 : ((win > MAX_WIN) ? MAX_WIN : win);
            n_in++;
            if (restart) begin
                depth = 0;
                pos = '0;
                fill = 0;
                n_restart++;
            end
            // evict front candidates that aged out of the window
            stale = 1'b1;
            while (depth > 0 && stale) begin
                d = pos - cand_pos[0];
                age = (d == 0) ? MAX_WIN : d;
                if (age >= w) begin
                    for (int i = 0; i + 1 < depth; i++) begin
                        cand_val[i] = cand_val[i+1];
                        cand_pos[i] = cand_pos[i+1];
                    end
                    depth--;
                end else begin
                    stale = 1'b0;
                end
            end
            // drop smaller back candidates, keep equal ones
            while (depth > 0 && s > cand_val[depth-1])
                depth--;
            if (depth < MAX_WIN) begin
                cand_val[depth] = s;
                cand_pos[depth] = pos;
                depth++;
            end
            pos = pos + 1'b1;
            if (fill < MAX_WIN)
                fill++;
            if (fill >= w)
                exp_q.insert(exp_q.size(), cand_val[0]);
        endfunction

        function void check_result(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            n_out++;
            if (exp_q.size() == 0) begin
                $error("window_max: expected none, actual %0d", got);
                n_err++;
            end else begin
                want = exp_q[0];
                exp_q.delete(0);
                if (got !== want) begin
                    $error("window_max: expected %0d, actual %0d", want, got);
                    n_err++;
                end
            end
        endfunction
    endclass

    swm_scoreboard sb;
    bit          quiet_tail = 1'b0;
    bit          long_hold_done = 1'b0;
    int          ramp_val = 0;
    int unsigned n_windows = 0;
    int unsigned idle_cycles = 0;

    sliding_window_maximum_core #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SMP_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // monitors: inputs, results and register writes seen at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wen)
                sb.set_window(i_cfg_wdata);
            if (i_s_tvalid && o_s_tready)
                sb.note_sample(i_s_tdata, i_s_tuser);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wen)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sliding_window_maximum_core verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold
    initial begin
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && sb.n_out >= 400) begin
                long_hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [SMP_W-1:0] s, input logic restart);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        i_s_tuser  <= restart;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        n_windows++;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample(int mode);
        logic [SMP_W-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = SMP_W'(int'($urandom_range(0, 16)) - 8);
            2: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h8000_0001;
                    default: v = 32'h7fff_fffe;
                endcase
            end
            default: begin
                ramp_val = ramp_val + int'($urandom_range(0, 6)) - 3;
                v = ramp_val;
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [SMP_W-1:0]          dir_smp[14];
        logic [swm_pkg::CFG_W-1:0] w;
        int unsigned               done_items;
        int unsigned               len;
        int                        mode;
        int                        phase;
        bit                        src_idle;

        sb = new();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, equal samples, decreasing and rising runs, restart
        dir_smp = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                    32'd5, 32'd5, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1,
                    32'd2, 32'd3, 32'h8000_0000};
        write_window(7'd3);
        for (int i = 0; i < 14; i++)
            send_sample(dir_smp[i], (i == 0) || (i == 13));
        send_sample(32'h8000_0001, 1'b0);
        send_sample(32'h7fff_fffe, 1'b0);
        wait_idle();
        // shrink to a zero window mid-sequence
        write_window(7'd0);
        send_sample(32'd9, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd8, 1'b0);
        wait_idle();
        // grow mid-sequence
        write_window(7'd5);
        for (int i = 0; i < 4; i++)
            send_sample(32'hffff_fff0 + i, 1'b0);
        wait_idle();

        // random phases
        done_items = 0;
        phase = 0;
        while (done_items < RAND_ITEMS) begin
            case (phase)
                0: w = 7'd127;
                1: w = 7'd64;
                default: begin
                    case ($urandom_range(0, 11))
                        0: w = 7'd0;
                        1: w = 7'd1;
                        2: w = 7'd2;
                        3: w = 7'd64;
                        4: w = 7'd127;
                        5: w = 7'd65;
                        6: w = 7'd63;
                        7: w = 7'($urandom_range(3, 8));
                        8: w = 7'($urandom_range(9, 32));
                        default: w = 7'($urandom_range(2, 6));
                    endcase
                end
            endcase
            wait_idle();
            write_window(w);
            quiet_tail = (done_items >= RAND_ITEMS - 250);
            len = (w > 32) ? $urandom_range(90, 160) : $urandom_range(40, 120);
            mode = $urandom_range(0, 3);
            src_idle = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++) begin
                if (!quiet_tail && src_idle && $urandom_range(0, 7) == 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
                if ($urandom_range(0, 15) == 0)
                    mode = $urandom_range(0, 3);
                send_sample(pick_sample(mode),
                            (i == 0 && $urandom_range(0, 1) == 1) ||
                            ($urandom_range(0, 39) == 0));
                done_items++;
            end
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d samples, %0d window maxima checked, %0d sequence restarts,",
                 sb.n_in, sb.n_out, sb.n_restart);
        $display("%0d window settings between 0 and 127, with output back-pressure.",
                 n_windows);
        if (sb.n_err == 0 && sb.exp_q.size() == 0)
            $display("sliding_window_maximum_core verification clean");
        else
            $display("sliding_window_maximum_core verification failed");
        $finish;
    end

endmodule

### files.f
design/swm_pkg.sv
design/swm_cell.sv
design/sliding_window_maximum_core.sv
verif/sliding_window_maximum_core_tb.sv
